// File: design/nested_interval_parent_finder_top_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the interval parent finder checker
// Shared property forms used by the port-level checker.
// -----------------------------------------------------------------------------
`ifndef NESTED_INTERVAL_PARENT_FINDER_TOP_ASSERT_SVH
`define NESTED_INTERVAL_PARENT_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NIPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nipf check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define NIPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nipf check failed: next-cycle rule");

`endif

// File: design/nipf_pkg.sv
// -----------------------------------------------------------------------------
// nipf_pkg
// Widths, stack geometry and the stack entry type of the parent finder.
// -----------------------------------------------------------------------------
package nipf_pkg;

    localparam int POS_BITS    = 24;
    localparam int IDX_BITS    = 24;
    localparam int STACK_DEPTH = 1024;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int FILL_BITS   = STACK_AW + 1;

    // tdata is two 24-bit fields, already a whole number of bytes
    localparam int IN_DATA_BITS  = 2 * POS_BITS;
    localparam int OUT_DATA_BITS = 2 * IDX_BITS;
    localparam int OUT_USER_BITS = 2;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic [POS_BITS-1:0] lo;
        logic [POS_BITS-1:0] hi;
    } stack_entry_t;

    localparam int ENTRY_BITS = $bits(stack_entry_t);

endpackage

// File: design/nipf_ram.sv
// -----------------------------------------------------------------------------
// nipf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module nipf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/nested_interval_parent_finder_top.sv
// An accepted interval moves from ST_IDLE to ST_TEST; a pop that leaves entries
// goes through ST_WAIT, one that empties the stack stays in ST_TEST, and a stalled
// result adds its stall. New input waits for ST_IDLE; pops amortize to at most one per
// item. The cost of a pop is set by the single stack RAM read port (registered read).
// Reset (rst_n low, asynchronous) empties the stack, zeroes the sequence counter
// and drops any pending result; the stack RAM itself is not cleared.
// -----------------------------------------------------------------------------
// nested_interval_parent_finder_top
// Stack-based containment tree builder: for each incoming interval, pop open
// intervals until one encloses it, report that one as parent, push the new one.
// -----------------------------------------------------------------------------
module nested_interval_parent_finder_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [23:0] interval_start, [47:24] interval_end
    input  logic [nipf_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // [0] first_of_set
    input  logic [0:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [23:0] item_index, [47:24] parent_index
    output logic [nipf_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // [0] has_parent, [1] stack_overflow
    output logic [nipf_pkg::OUT_USER_BITS-1:0]    m_axis_tuser
);

    // Sequencer states: wait for an interval, test the cached top, wait on a RAM read.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TEST = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam int PB = nipf_pkg::POS_BITS;
    localparam int IB = nipf_pkg::IDX_BITS;
    localparam int FB = nipf_pkg::FILL_BITS;
    localparam int AW = nipf_pkg::STACK_AW;

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [FB-1:0] fill_reg, fill_next;
    logic [IB-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state
    logic [IB-1:0]          cur_idx_reg, cur_idx_next;
    logic [PB-1:0]          cur_lo_reg, cur_lo_next;
    logic [PB-1:0]          cur_hi_reg, cur_hi_next;
    nipf_pkg::stack_entry_t top_reg, top_next;
    logic [IB-1:0]          out_item_reg, out_item_next;
    logic [IB-1:0]          out_parent_reg, out_parent_next;
    logic                   out_has_reg, out_has_next;
    logic                   out_ovf_reg, out_ovf_next;

    // Stack RAM port signals
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    nipf_pkg::stack_entry_t ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    nipf_pkg::stack_entry_t ram_rd_data;

    logic          in_xfer;
    logic          out_free;
    logic          encloses;
    logic          in_first;
    logic [IB-1:0] base_count;
    logic [FB-1:0] fill_minus2;

    // The top of the stack lives in top_reg whenever fill_reg is nonzero, outside ST_WAIT;
    // the RAM holds every entry, so a pop only needs the one below.
    nipf_ram #(
        .WIDTH (nipf_pkg::ENTRY_BITS),
        .DEPTH (nipf_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_first      = s_axis_tuser[0];
    assign base_count    = in_first ? '0 : count_reg;

    // A result can be loaded when the output register is empty or draining now.
    assign out_free = !out_valid_reg || m_axis_tready;

    // Equal bounds count as enclosing.
    assign encloses = (top_reg.lo <= cur_lo_reg) && (cur_hi_reg <= top_reg.hi);

    assign fill_minus2 = fill_reg - FB'(2);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        cur_idx_next    = cur_idx_reg;
        cur_lo_next     = cur_lo_reg;
        cur_hi_next     = cur_hi_reg;
        top_next        = top_reg;
        out_item_next   = out_item_reg;
        out_parent_next = out_parent_reg;
        out_has_next    = out_has_reg;
        out_ovf_next    = out_ovf_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = fill_reg[AW-1:0];
        ram_wr_data = '{idx: cur_idx_reg, lo: cur_lo_reg, hi: cur_hi_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = fill_minus2[AW-1:0];

        // Drop the result once the sink takes it.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Start of a set empties the stack and restarts numbering.
                    cur_lo_next  = s_axis_tdata[PB-1:0];
                    cur_hi_next  = s_axis_tdata[2*PB-1:PB];
                    cur_idx_next = base_count;
                    count_next   = base_count + IB'(1);
                    if (in_first)
                    begin
                        fill_next = '0;
                    end
                    state_next = ST_TEST;
                end
            end

            ST_TEST:
            begin
                if ((fill_reg != '0) && !encloses)
                begin
                    // Pop the top; fetch the entry below it if there is one.
                    fill_next = fill_reg - FB'(1);
                    if (fill_reg > FB'(1))
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_WAIT;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = cur_idx_reg;
                    out_has_next    = (fill_reg != '0);
                    out_parent_next = (fill_reg != '0) ? top_reg.idx : '0;
                    if (fill_reg < FB'(nipf_pkg::STACK_DEPTH))
                    begin
                        // Push the new interval; it becomes the cached top.
                        ram_wr_en    = 1'b1;
                        top_next     = ram_wr_data;
                        fill_next    = fill_reg + FB'(1);
                        out_ovf_next = 1'b0;
                    end
                    else
                    begin
                        out_ovf_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_WAIT:
            begin
                // Read data for the new top is valid now.
                top_next   = ram_rd_data;
                state_next = ST_TEST;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg    <= cur_idx_next;
        cur_lo_reg     <= cur_lo_next;
        cur_hi_reg     <= cur_hi_next;
        top_reg        <= top_next;
        out_item_reg   <= out_item_next;
        out_parent_reg <= out_parent_next;
        out_has_reg    <= out_has_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_parent_reg, out_item_reg};
    assign m_axis_tuser  = {out_ovf_reg, out_has_reg};

endmodule

// File: design/nipf_checker.sv
// -----------------------------------------------------------------------------
// nipf_checker
// Port-level checks on the parent finder, bound to the top level.
// -----------------------------------------------------------------------------
`include "nested_interval_parent_finder_top_assert.svh"

module nipf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [nipf_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input logic [0:0]                         s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [nipf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [nipf_pkg::OUT_USER_BITS-1:0] m_axis_tuser
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled result holds until taken.
    `NIPF_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // The sequencer is busy in the cycle after taking an interval.
    `NIPF_ASSERT_NEXT(a_busy_after_accept, in_xfer, !s_axis_tready)

    // Without a parent, the parent index reads zero.
    `NIPF_ASSERT_NOW(a_no_parent_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[nipf_pkg::OUT_DATA_BITS-1:nipf_pkg::IDX_BITS] == '0)

    // A full stack is never empty, so an overflow always has a parent.
    `NIPF_ASSERT_NOW(a_overflow_has_parent, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])

endmodule

bind nested_interval_parent_finder_top nipf_checker u_nipf_checker (.*);

// File: tb/nipf_parent_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nipf_parent_checker
// Watches both stream ports of the parent finder. Predicts the parent report
// of every accepted interval and compares each returned report with the oldest
// prediction.
// -----------------------------------------------------------------------------
module nipf_parent_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // [23:0] interval_start, [47:24] interval_end
    input  logic [nipf_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // [0] first_of_set
    input  logic [0:0]                            s_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [23:0] item_index, [47:24] parent_index
    input  logic [nipf_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // [0] has_parent, [1] stack_overflow
    input  logic [nipf_pkg::OUT_USER_BITS-1:0]    m_axis_tuser,
    output int unsigned                           mismatch_count,
    output int unsigned                           reports_outstanding
);

    localparam int P = nipf_pkg::POS_BITS;
    localparam int I = nipf_pkg::IDX_BITS;

    typedef struct packed {
        logic [I-1:0] item_index;
        logic [I-1:0] parent_index;
        logic         has_parent;
        logic         stack_overflow;
    } parent_report_t;

    nipf_pkg::stack_entry_t open_stack [nipf_pkg::STACK_DEPTH];
    int unsigned            open_fill = 0;
    logic [I-1:0]           next_seq = '0;
    parent_report_t         pending_reports [$];
    parent_report_t         seen_report;
    parent_report_t         want_report;
    int unsigned            bad_fields = 0;

    assign mismatch_count = bad_fields;

    // Advance the open-interval stack by one interval and return its report.
    function automatic parent_report_t predict_parent(input logic [P-1:0] lo,
                                                      input logic [P-1:0] hi,
                                                      input logic first);
        parent_report_t rep;
        rep = '0;
        if (first)
        begin
            open_fill = 0;
            next_seq  = '0;
        end
        rep.item_index = next_seq;
        next_seq       = next_seq + 1'b1;
        // drop open intervals that do not enclose the new one
        while (open_fill > 0 && !(open_stack[open_fill-1].lo <= lo
                                  && hi <= open_stack[open_fill-1].hi))
            open_fill--;
        if (open_fill > 0)
        begin
            rep.parent_index = open_stack[open_fill-1].idx;
            rep.has_parent   = 1'b1;
        end
        if (open_fill < nipf_pkg::STACK_DEPTH)
        begin
            open_stack[open_fill].idx = rep.item_index;
            open_stack[open_fill].lo  = lo;
            open_stack[open_fill].hi  = hi;
            open_fill++;
        end
        else
            rep.stack_overflow = 1'b1;
        return rep;
    endfunction

    task automatic note_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            if (bad_fields < 10)
                $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what,
                         want, got);
            bad_fields++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_fill = 0;
            next_seq  = '0;
            pending_reports.delete();
            reports_outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_report.item_index     = m_axis_tdata[I-1:0];
                seen_report.parent_index   = m_axis_tdata[2*I-1:I];
                seen_report.has_parent     = m_axis_tuser[0];
                seen_report.stack_overflow = m_axis_tuser[1];
                if (pending_reports.size() == 0)
                begin
                    if (bad_fields < 10)
                        $display("%0t unexpected result: item_index 0x%0h parent 0x%0h",
                                 $realtime, seen_report.item_index,
                                 seen_report.parent_index);
                    bad_fields++;
                end
                else
                begin
                    want_report = pending_reports.pop_front();
                    note_field("item_index", 32'(want_report.item_index),
                               32'(seen_report.item_index));
                    note_field("parent_index", 32'(want_report.parent_index),
                               32'(seen_report.parent_index));
                    note_field("has_parent", 32'(want_report.has_parent),
                               32'(seen_report.has_parent));
                    note_field("stack_overflow", 32'(want_report.stack_overflow),
                               32'(seen_report.stack_overflow));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_reports.insert(pending_reports.size(),
                                       predict_parent(s_axis_tdata[P-1:0],
                                                      s_axis_tdata[2*P-1:P],
                                                      s_axis_tuser[0]));
            reports_outstanding <= pending_reports.size();
        end
    end

endmodule

// File: tb/tb_nested_interval_parent_finder_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_nested_interval_parent_finder_top
// Stimulus and verdict for the interval parent finder. Sends directed corner
// intervals, one very deep nesting chain that runs the stack full, and random
// containment trees with noise; ports idle at random except in the chain. A
// checker beside the block predicts and compares every parent report.
// -----------------------------------------------------------------------------
module tb_nested_interval_parent_finder_top;

    localparam int          P       = nipf_pkg::POS_BITS;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    // [23:0] interval_start, [47:24] interval_end
    logic [nipf_pkg::IN_DATA_BITS-1:0]    s_axis_tdata = '0;
    // [0] first_of_set
    logic [0:0]                           s_axis_tuser = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    // [23:0] item_index, [47:24] parent_index
    logic [nipf_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;
    // [0] has_parent, [1] stack_overflow
    logic [nipf_pkg::OUT_USER_BITS-1:0]   m_axis_tuser;

    int unsigned mismatch_count;
    int unsigned reports_outstanding;

    // Random idling on both ports; cleared for the long no-idle stretch.
    logic idle_on = 1'b1;

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nested_interval_parent_finder_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    nipf_parent_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .mismatch_count      (mismatch_count),
        .reports_outstanding (reports_outstanding)
    );

    // Result side: stall at random about 19 percent of the time while idling is on.
    always @(posedge clk)
    begin
        m_axis_tready <= !(idle_on && ($urandom_range(0, 99) < 19));
    end

    // Offer one interval and hold it until the transfer completes. Called at a
    // rising edge; returns at the edge of the transfer with tvalid still high,
    // so back-to-back intervals keep tvalid up without a glitch.
    task automatic send_interval(input logic [P-1:0] lo, input logic [P-1:0] hi,
                                 input logic first);
        while (idle_on && ($urandom_range(0, 99) < 19))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop tvalid and hold off until every predicted report has come back.
    // The first edge lets the outstanding count see the last transfer.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned  n;
        int unsigned  roll;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  par_lo;
        int unsigned  par_hi;
        int unsigned  tree_lo [$];
        int unsigned  tree_hi [$];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed corners, random idling on ----
        send_interval('0, POS_MAX, 1'b1);          // full-range root, no parent
        send_interval('0, '0, 1'b0);               // smallest child of the root
        send_interval(24'd1, 24'd10, 1'b0);        // pops the point, root parent
        send_interval(24'd1, 24'd10, 1'b0);        // equal interval encloses
        send_interval(24'd5, 24'd5, 1'b0);
        send_interval(POS_MAX, POS_MAX, 1'b0);     // pops back to the root
        send_interval(24'd10, 24'd5, 1'b0);        // inverted bounds
        send_interval(24'd20, 24'd30, 1'b0);       // inverted one cannot enclose
        send_interval(24'd100, 24'd200, 1'b0);
        send_interval(24'd50, 24'd300, 1'b0);      // out of order: discard sibling
        send_interval(24'd7, 24'd9, 1'b1);         // new set with a nonempty stack
        send_interval('0, 24'd5, 1'b0);            // not enclosed: no parent
        send_interval('0, '0, 1'b1);
        send_interval(POS_MAX, '0, 1'b0);          // extreme inverted interval
        send_interval(POS_MAX, POS_MAX, 1'b1);
        send_interval('0, POS_MAX, 1'b0);          // encloses the old top, no parent
        drain_results();

        // ---- deep nesting chain, no idling: fills the stack and overflows ----
        idle_on <= 1'b0;
        lo = $urandom_range(0, 15);
        hi = 32'(POS_MAX) - $urandom_range(0, 15);
        send_interval(P'(lo), P'(hi), 1'b1);
        for (n = 0; n < nipf_pkg::STACK_DEPTH + 10; n++)
        begin
            lo = lo + $urandom_range(0, 3);
            hi = hi - $urandom_range(0, 3);
            send_interval(P'(lo), P'(hi), 1'b0);
        end
        drain_results();

        // ---- random containment trees with noise; the first one unwinds the
        //      full stack left by the chain ----
        idle_on <= 1'b1;
        for (n = 0; n < 560; n++)
        begin
            if (n == 280)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                // start a new set at a random root
                tree_lo.delete();
                tree_hi.delete();
                lo = $urandom_range(0, POS_MAX);
                hi = $urandom_range(lo, POS_MAX);
                tree_lo.insert(tree_lo.size(), lo);
                tree_hi.insert(tree_hi.size(), hi);
                send_interval(P'(lo), P'(hi), 1'b1);
            end
            else if (roll < 15)
            begin
                // noise: any bounds, inverted ones included
                send_interval(P'($urandom_range(0, POS_MAX)),
                              P'($urandom_range(0, POS_MAX)), 1'b0);
            end
            else
            begin
                // close a few levels, then open a child inside the current parent
                while (tree_lo.size() > 0 && $urandom_range(0, 2) == 0)
                begin
                    tree_lo.delete(tree_lo.size() - 1);
                    tree_hi.delete(tree_hi.size() - 1);
                end
                if (tree_lo.size() == 0)
                begin
                    par_lo = 0;
                    par_hi = 32'(POS_MAX);
                end
                else
                begin
                    par_lo = tree_lo[$];
                    par_hi = tree_hi[$];
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    lo = par_lo;
                    hi = par_hi;
                end
                else
                begin
                    lo = $urandom_range(par_lo, par_hi);
                    hi = $urandom_range(lo, par_hi);
                end
                tree_lo.insert(tree_lo.size(), lo);
                tree_hi.insert(tree_hi.size(), hi);
                send_interval(P'(lo), P'(hi), 1'b0);
            end
        end

        // ---- wind down: wait out every report, then idle before the verdict ----
        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && reports_outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #800000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
